// ===== src/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB colour converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// Width of one colour channel and of the hue fraction.
	localparam int CH_BITS = 16;

	typedef logic [CH_BITS-1:0] chan_t;
	// One bit wider than a channel so that the exact value 1.0 (2^CH_BITS) fits.
	typedef logic [CH_BITS:0]   opnd_t;
	// Hue times six: three sector bits above the fraction.
	typedef logic [CH_BITS+2:0] hue6_t;

	localparam opnd_t CH_ONE = opnd_t'(1) << CH_BITS;

	// Hue sectors of sixty degrees each.
	typedef enum logic [2:0] {
		SECT_RY = 3'd0,
		SECT_YG = 3'd1,
		SECT_GC = 3'd2,
		SECT_CB = 3'd3,
		SECT_BM = 3'd4,
		SECT_MR = 3'd5
	} sector_t;

endpackage : hsvrgb_pkg

// ===== src/hsvrgb_fxmul.sv =====
// Fixed-point fraction multiplier: (a * b) truncated to a channel-wide result.
`timescale 1ns / 1ps

module hsvrgb_fxmul (
	input  hsvrgb_pkg::chan_t a,
	input  hsvrgb_pkg::opnd_t b,
	output hsvrgb_pkg::chan_t y
);
	import hsvrgb_pkg::*;

	logic [2*CH_BITS:0] prod;

	// b never exceeds 1.0, so the shifted product always fits one channel.
	assign prod = {{(CH_BITS+1){1'b0}}, a} * {{CH_BITS{1'b0}}, b};
	assign y    = prod[CH_BITS +: CH_BITS];

endmodule : hsvrgb_fxmul

// ===== src/hsv_to_rgb_converter_unit.sv =====
// Top level of the HSV to RGB colour converter with alpha pass-through.
// An accepted input passes registered stages one to four; stage four drives the output.
// Throughput: one pixel per cycle while the output is not stalled; stages two and three
// hold three and two 16 by 17 bit multipliers and set the clock; output stall back-pressures.
// Reset: arst_n clears every stage valid bit asynchronously; payload registers keep no reset.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hsvrgb_pkg::chan_t hue,
	input  hsvrgb_pkg::chan_t saturation,
	input  hsvrgb_pkg::chan_t brightness,
	input  hsvrgb_pkg::chan_t alpha_in,
	output logic              out_valid,
	input  logic              out_stall,
	output hsvrgb_pkg::chan_t red,
	output hsvrgb_pkg::chan_t green,
	output hsvrgb_pkg::chan_t blue,
	output hsvrgb_pkg::chan_t alpha_out
);
	import hsvrgb_pkg::*;

	// Each stage advances when it is empty or the stage after it advances, so bubbles
	// are squeezed out and a full pipeline keeps accepting while the output is taken.
	logic adv1, adv2, adv3, adv4;

	// Stage 1: hue times six is split into a sector and a fraction.
	logic    valid_s1;
	sector_t sector_s1;
	chan_t   frac_s1;
	chan_t   sat_s1;
	chan_t   val_s1;
	chan_t   alpha_s1;
	logic    grey_s1;

	// Stage 2: p and the two saturation products s*f and s*(1-f).
	logic    valid_s2;
	sector_t sector_s2;
	chan_t   sf_s2;
	chan_t   sfc_s2;
	chan_t   p_s2;
	chan_t   val_s2;
	chan_t   alpha_s2;
	logic    grey_s2;

	// Stage 3: q and t.
	logic    valid_s3;
	sector_t sector_s3;
	chan_t   p_s3;
	chan_t   q_s3;
	chan_t   t_s3;
	chan_t   val_s3;
	chan_t   alpha_s3;
	logic    grey_s3;

	// Stage 4: routed colour outputs, which also serve as the output register.
	logic    valid_s4;
	chan_t   red_s4;
	chan_t   green_s4;
	chan_t   blue_s4;
	chan_t   alpha_s4;
	logic    grey_s4;
	chan_t   val_s4;

	hue6_t   hue6;
	opnd_t   frac_c;
	chan_t   sf_c, sfc_c, p_c, q_c, t_c;
	chan_t   red_c, green_c, blue_c;

	assign adv4     = !valid_s4 || !out_stall;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	// Multiplication by six as two shifted additions.
	assign hue6 = (hue6_t'(hue) << 2) + (hue6_t'(hue) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sector_s1 <= sector_t'(hue6[CH_BITS +: 3]);
			frac_s1   <= hue6[CH_BITS-1:0];
			sat_s1    <= saturation;
			val_s1    <= brightness;
			alpha_s1  <= alpha_in;
			grey_s1   <= (saturation == '0);
		end
	end

	// The complement of the fraction is taken against exactly 1.0, so f = 0 gives 1.0.
	assign frac_c = CH_ONE - {1'b0, frac_s1};

	hsvrgb_fxmul u_mul_sf  (.a(sat_s1), .b({1'b0, frac_s1}), .y(sf_c));
	hsvrgb_fxmul u_mul_sfc (.a(sat_s1), .b(frac_c),          .y(sfc_c));
	hsvrgb_fxmul u_mul_p   (.a(val_s1), .b({1'b0, ~sat_s1}), .y(p_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			sector_s2 <= sector_s1;
			sf_s2     <= sf_c;
			sfc_s2    <= sfc_c;
			p_s2      <= p_c;
			val_s2    <= val_s1;
			alpha_s2  <= alpha_s1;
			grey_s2   <= grey_s1;
		end
	end

	// Full scale minus a channel value is its bitwise complement.
	hsvrgb_fxmul u_mul_q (.a(val_s2), .b({1'b0, ~sf_s2}),  .y(q_c));
	hsvrgb_fxmul u_mul_t (.a(val_s2), .b({1'b0, ~sfc_s2}), .y(t_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			sector_s3 <= sector_s2;
			p_s3      <= p_s2;
			q_s3      <= q_c;
			t_s3      <= t_c;
			val_s3    <= val_s2;
			alpha_s3  <= alpha_s2;
			grey_s3   <= grey_s2;
		end
	end

	// Sector routing; zero saturation overrides it with grey.
	always_comb begin
		red_c   = val_s3;
		green_c = val_s3;
		blue_c  = val_s3;
		if (!grey_s3) begin
			unique case (sector_s3)
				SECT_RY: begin
					red_c = val_s3; green_c = t_s3;   blue_c = p_s3;
				end
				SECT_YG: begin
					red_c = q_s3;   green_c = val_s3; blue_c = p_s3;
				end
				SECT_GC: begin
					red_c = p_s3;   green_c = val_s3; blue_c = t_s3;
				end
				SECT_CB: begin
					red_c = p_s3;   green_c = q_s3;   blue_c = val_s3;
				end
				SECT_BM: begin
					red_c = t_s3;   green_c = p_s3;   blue_c = val_s3;
				end
				default: begin
					red_c = val_s3; green_c = p_s3;   blue_c = q_s3;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			red_s4   <= red_c;
			green_s4 <= green_c;
			blue_s4  <= blue_c;
			alpha_s4 <= alpha_s3;
			grey_s4  <= grey_s3;
			val_s4   <= val_s3;
		end
	end

	assign out_valid = valid_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;
	assign alpha_out = alpha_s4;

	// A grey pixel has all three colour components equal to its brightness.
	a_grey_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && grey_s4) |-> (red == val_s4 && green == val_s4 && blue == val_s4))
		else $error("grey pixel has unequal colour components");

	// The brightest component always equals the value, and none exceeds it.
	a_max_is_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ((red == val_s4 || green == val_s4 || blue == val_s4)
			&& red <= val_s4 && green <= val_s4 && blue <= val_s4))
		else $error("colour component does not match brightness bound");

	// An empty first stage never back-pressures the input.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	// A stalled stage three keeps its transaction rather than dropping it.
	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !adv3) |=> (valid_s3 && $stable(q_s3) && $stable(t_s3)))
		else $error("stalled stage three lost its contents");

endmodule : hsv_to_rgb_converter_unit
